@@ hw/rtl/qpf_pkg.sv @@
// ---------------------------------------------------------------------------
// qpf_pkg: shared types and constants of the quadratic peak fit
// Holds the sequencer state type and the fixed widths of the datapath.
// ---------------------------------------------------------------------------
`default_nettype none
package qpf_pkg;
  localparam int unsigned MaxPoints = 256;
  localparam int unsigned CntW      = 9;
  localparam int unsigned WideW     = 128;
  localparam int unsigned MulSteps  = 72;
  localparam int unsigned DivSteps  = 128;

  localparam logic [1:0] StatOk    = 2'd0;
  localparam logic [1:0] StatDegen = 2'd1;
  localparam logic [1:0] StatSat   = 2'd2;

  localparam logic [23:0] PosLimit = 24'h7FFFFF;
  localparam logic [23:0] NegLimit = 24'h800000;

  typedef enum logic [2:0] {
    ST_IDLE, ST_ACC, ST_MUL, ST_PREP, ST_DIV, ST_OUT
  } qpf_state_t;
endpackage
`default_nettype wire

@@ hw/rtl/quadratic_peak_fit.sv @@
// ---------------------------------------------------------------------------
// quadratic_peak_fit: least-squares parabola vertex over a run of samples
// Accumulates power sums per sample with one shared 32x32-bit multiplier,
// then solves the vertex by Cramer's rule and a restoring divider.
// ---------------------------------------------------------------------------
// A sample that is not the last of its run makes four passes
// through the shared multiplier before in_tready rises again. A last sample
// then runs 18 wide products of four 32-bit limb passes each, two
// preparation steps and 128 divide steps before out_tvalid rises, and skips
// the divide when degenerate (Da zero); it waits while the output is held.
// A new sample is taken only in ST_IDLE, once the last one and any fit are through.
// Reset (rst_n low, synchronous) clears the run and empties the output.
`default_nettype none
module quadratic_peak_fit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [7:0] start_x, [15:8] sample
  input  wire logic        in_tlast,   // last_sample
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata   // [23:0] peak_pos, [25:24] fit_status, rest 0
);
  import qpf_pkg::*;

  // Sequencer state and the run sums.
  qpf_state_t st_r, st_nxt;
  logic [6:0]  step_r, step_nxt;
  logic        last_r;
  logic [7:0]  y_r, x_r;
  logic [CntW-1:0] cnt_r;
  logic [7:0]  cur_x_r;
  logic [15:0] sx1_r, sy_r;
  logic [23:0] sx2_r, sxy_r;
  logic [31:0] sx3_r, sx2y_r;
  logic [39:0] sx4_r;
  logic [15:0] x2_r;
  logic        res_load;

  // During the solve the step counter splits into a product index and the
  // limb pair that the multiplier works on.
  logic [4:0] idx;
  logic [1:0] limb;
  assign idx  = step_r[6:2];
  assign limb = step_r[1:0];

  // The one shared multiplier.
  logic [31:0] pa, pb;
  logic [63:0] mprod;
  assign mprod = 64'(pa) * 64'(pb);

  // The sums as nonnegative wide operands.
  logic [63:0] a0, a1, a2, a3, a4, b0, b1, b2;
  assign a0 = 64'(cnt_r);  assign a1 = 64'(sx1_r); assign a2 = 64'(sx2_r);
  assign a3 = 64'(sx3_r);  assign a4 = 64'(sx4_r); assign b0 = 64'(sy_r);
  assign b1 = 64'(sxy_r);  assign b2 = 64'(sx2y_r);

  // Wide product operands, the signed accumulator and the six cofactors.
  logic [63:0]             opa, opb_mag;
  logic signed [63:0]      opb;
  logic                    op_sub, term_neg;
  logic signed [WideW-1:0] term, acc_r, acc_sum, da_r, db_r;
  logic signed [63:0]      c_r [6];

  // Divider registers.
  logic [WideW-1:0] num_r, den_r, rem_r, quo_r, da_mag;
  logic             neg_r;
  logic [WideW-1:0] rem_sh, rem_sub;
  assign rem_sh  = {rem_r[WideW-2:0], num_r[WideW-1]};
  assign rem_sub = rem_sh - den_r;
  assign da_mag  = da_r[WideW-1] ? -da_r : da_r;

  logic [23:0] pos_r, pos_nxt;
  logic [1:0]  stat_r, stat_nxt;
  logic        ovalid_r;

  assign out_tdata = {6'd0, stat_r, pos_r};

  // Product schedule of the solve. The first twelve products form the six
  // 2x2 cofactors in pairs, the last six expand Da and Db along one column.
  always_comb begin
    opa    = '0;
    opb    = '0;
    op_sub = 1'b0;
    unique case (idx)
      5'd0:  begin opa = a2; opb = a0; end
      5'd1:  begin opa = a1; opb = a1; op_sub = 1'b1; end
      5'd2:  begin opa = a3; opb = a0; end
      5'd3:  begin opa = a1; opb = a2; op_sub = 1'b1; end
      5'd4:  begin opa = a3; opb = a1; end
      5'd5:  begin opa = a2; opb = a2; op_sub = 1'b1; end
      5'd6:  begin opa = b1; opb = a0; end
      5'd7:  begin opa = b0; opb = a1; op_sub = 1'b1; end
      5'd8:  begin opa = b2; opb = a0; end
      5'd9:  begin opa = b0; opb = a2; op_sub = 1'b1; end
      5'd10: begin opa = b2; opb = a1; end
      5'd11: begin opa = b1; opb = a2; op_sub = 1'b1; end
      5'd12: begin opa = b2; opb = c_r[0]; end
      5'd13: begin opa = b1; opb = c_r[1]; op_sub = 1'b1; end
      5'd14: begin opa = b0; opb = c_r[2]; end
      5'd15: begin opa = a4; opb = c_r[3]; end
      5'd16: begin opa = a3; opb = c_r[4]; op_sub = 1'b1; end
      5'd17: begin opa = a2; opb = c_r[5]; end
      default: begin opa = '0; opb = '0; end
    endcase
  end

  // Multiplier inputs and the shifted, signed partial product.
  always_comb begin
    opb_mag  = opb[63] ? -opb : opb;
    term_neg = op_sub ^ opb[63];
    if (st_r == ST_ACC) begin
      unique case (step_r[1:0])
        // x * (y * 2^16 + x) gives x^2 in the low half and x*y above it.
        2'd0: begin pa = 32'(x_r);  pb = {8'd0, y_r, 8'd0, x_r}; end
        2'd1: begin pa = 32'(x2_r); pb = 32'(x_r); end
        2'd2: begin pa = 32'(x2_r); pb = 32'(x2_r); end
        default: begin pa = 32'(y_r); pb = 32'(x2_r); end
      endcase
    end else begin
      pa = limb[1] ? opa[63:32] : opa[31:0];
      pb = limb[0] ? opb_mag[63:32] : opb_mag[31:0];
    end
    unique case (limb)
      2'd0:    term = WideW'(mprod);
      2'd3:    term = WideW'(mprod) << 64;
      default: term = WideW'(mprod) << 32;
    endcase
    acc_sum = term_neg ? acc_r - term : acc_r + term;
  end

  // Rounded and saturated vertex from the quotient.
  always_comb begin
    pos_nxt  = '0;
    stat_nxt = StatDegen;
    if (da_r != '0) begin
      if (neg_r) begin
        if (quo_r > WideW'(NegLimit)) begin
          pos_nxt = NegLimit; stat_nxt = StatSat;
        end else begin
          pos_nxt = 24'd0 - quo_r[23:0]; stat_nxt = StatOk;
        end
      end else begin
        if (quo_r > WideW'(PosLimit)) begin
          pos_nxt = PosLimit; stat_nxt = StatSat;
        end else begin
          pos_nxt = quo_r[23:0]; stat_nxt = StatOk;
        end
      end
    end
  end

  // Handshake outputs. A waiting result does not hold off new samples; only
  // the next fit waits in ST_OUT until the output register is free.
  always_comb begin
    in_tready  = (st_r == ST_IDLE);
    out_tvalid = ovalid_r;
    res_load   = (st_r == ST_OUT) && (!ovalid_r || out_tready);
  end

  // Next-state logic.
  always_comb begin
    st_nxt   = st_r;
    step_nxt = step_r + 7'd1;
    unique case (st_r)
      ST_IDLE: begin
        step_nxt = '0;
        if (in_tvalid && in_tready) st_nxt = ST_ACC;
      end
      ST_ACC: if (step_r == 7'd3) begin
        step_nxt = '0;
        st_nxt   = last_r ? ST_MUL : ST_IDLE;
      end
      ST_MUL: if (step_r == 7'(MulSteps - 1)) begin
        step_nxt = '0;
        st_nxt   = ST_PREP;
      end
      ST_PREP: if (step_r == 7'd1) begin
        step_nxt = '0;
        st_nxt   = (da_r == '0) ? ST_OUT : ST_DIV;
      end
      ST_DIV: if (step_r == 7'(DivSteps - 1)) begin
        step_nxt = '0;
        st_nxt   = ST_OUT;
      end
      ST_OUT: begin
        step_nxt = '0;
        if (res_load) st_nxt = ST_IDLE;
      end
      default: begin
        step_nxt = '0;
        st_nxt   = ST_IDLE;
      end
    endcase
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; step_r <= '0; ovalid_r <= 1'b0;
      cnt_r <= '0; cur_x_r <= '0; acc_r <= '0;
      sx1_r <= '0; sx2_r <= '0; sx3_r <= '0; sx4_r <= '0;
      sy_r <= '0; sxy_r <= '0; sx2y_r <= '0;
    end else begin
      st_r   <= st_nxt;
      step_r <= step_nxt;
      if (res_load) ovalid_r <= 1'b1;
      else if (out_tready) ovalid_r <= 1'b0;
      unique case (st_r)
        ST_IDLE: if (in_tvalid && in_tready) begin
          y_r    <= in_tdata[15:8];
          last_r <= in_tlast;
          x_r    <= (cnt_r == '0) ? in_tdata[7:0] : cur_x_r;
          if (cnt_r == '0) cur_x_r <= in_tdata[7:0];
        end
        ST_ACC: if (cnt_r < CntW'(MaxPoints)) begin
          unique case (step_r[1:0])
            2'd0: begin
              x2_r  <= mprod[15:0];
              sx2_r <= sx2_r + 24'(mprod[15:0]);
              sx1_r <= sx1_r + 16'(x_r);
              sy_r  <= sy_r + 16'(y_r);
              sxy_r <= sxy_r + 24'(mprod[31:16]);
            end
            2'd1: sx3_r <= sx3_r + mprod[31:0];
            2'd2: sx4_r <= sx4_r + 40'(mprod[31:0]);
            default: begin
              sx2y_r  <= sx2y_r + mprod[31:0];
              cnt_r   <= cnt_r + CntW'(1);
              cur_x_r <= cur_x_r + 8'd1;
            end
          endcase
        end
        ST_MUL: begin
          // The last limb of a group hands the sum over and restarts at zero.
          if (limb == 2'd3 && idx <= 5'd11 && idx[0]) begin
            c_r[idx[3:1]] <= acc_sum[63:0];
            acc_r         <= '0;
          end else if (limb == 2'd3 && idx == 5'd14) begin
            da_r  <= acc_sum;
            acc_r <= '0;
          end else if (limb == 2'd3 && idx == 5'd17) begin
            db_r  <= acc_sum;
            acc_r <= '0;
          end else begin
            acc_r <= acc_sum;
          end
        end
        ST_PREP: begin
          if (step_r == 7'd0) begin
            num_r <= (-db_r) <<< 7;
          end else begin
            neg_r <= num_r[WideW-1] != da_r[WideW-1];
            num_r <= ((num_r[WideW-1] ? -num_r : num_r) << 1) + da_mag;
            den_r <= da_mag << 1;
            rem_r <= '0; quo_r <= '0;
          end
        end
        ST_DIV: begin
          num_r <= num_r << 1;
          if (rem_sh >= den_r) begin
            rem_r <= rem_sub; quo_r <= {quo_r[WideW-2:0], 1'b1};
          end else begin
            rem_r <= rem_sh;  quo_r <= {quo_r[WideW-2:0], 1'b0};
          end
        end
        ST_OUT: if (res_load) begin
          pos_r  <= pos_nxt;
          stat_r <= stat_nxt;
          cnt_r <= '0; cur_x_r <= '0;
          sx1_r <= '0; sx2_r <= '0; sx3_r <= '0; sx4_r <= '0;
          sy_r <= '0; sxy_r <= '0; sx2y_r <= '0;
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire
